### src/vmu_pkg.sv
package vmu_pkg;

  // operation codes
  localparam logic [2:0] FN_ADD   = 3'd0;
  localparam logic [2:0] FN_SUB   = 3'd1;
  localparam logic [2:0] FN_SCALE = 3'd2;
  localparam logic [2:0] FN_DOT   = 3'd3;
  localparam logic [2:0] FN_LEN   = 3'd4;
  localparam logic [2:0] FN_NORM  = 3'd5;
  localparam logic [2:0] FN_CROSS = 3'd6;
  localparam logic [2:0] FN_RSVD  = 3'd7;

  localparam int NLANE       = 3;
  localparam int SQ_W        = 64;
  localparam int ROOT_STAGES = 32;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [32:0] sum33_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [64:0] wide_t;

  localparam fx_t   FX_MAX = 32'sh7FFF_FFFF;
  localparam wide_t W_MAX  = 65'sd2147483647;
  localparam wide_t W_MIN  = -65'sd2147483648;

  // one queued word: operation, raw operands and the multiplier operands picked by the front
  typedef struct {
    logic [2:0] func;
    fx_t        ma [NLANE];
    fx_t        mb [NLANE];
    fx_t        na [NLANE];
    fx_t        nb [NLANE];
    fx_t        a  [NLANE];
    fx_t        b  [NLANE];
  } qent_t;

  // results settled so far, plus what normalize still needs
  typedef struct {
    logic [2:0]  func;
    fx_t         r   [NLANE];
    fx_t         sc;
    logic        ovf;
    logic [31:0] mag [NLANE];
    logic        neg [NLANE];
  } pay_t;

  typedef struct {
    fx_t  val;
    logic hit;
  } sat_t;

  // clamp to the 32-bit signed range
  function automatic sat_t sat32(input wide_t v);
    sat_t s;
    if (v > W_MAX) begin
      s.val = FX_MAX;
      s.hit = 1'b1;
    end else if (v < W_MIN) begin
      s.val = ~FX_MAX;
      s.hit = 1'b1;
    end else begin
      s.val = v[31:0];
      s.hit = 1'b0;
    end
    return s;
  endfunction

endpackage

### src/vector3_math_unit.sv
// Three-component vector ALU on signed fixed point (FRAC_BITS fraction bits in 32): add,
// subtract, scale, dot, length, normalize and cross. A word is taken when start is high and
// busy is low; one word per clock is sustained. Every operation passes through the same
// pipeline: the front register, the queue, three arithmetic stages, the 32-stage square
// root, the FRAC_BITS + 1 stage divider used by normalize and the output register. The result
// is shown for exactly one cycle and cannot be held off; busy only rises if the short queue
// between the front end and the execution pipeline fills.
module vector3_math_unit import vmu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_func,
  input  fx_t        in_a_x,
  input  fx_t        in_a_y,
  input  fx_t        in_a_z,
  input  fx_t        in_b_x,
  input  fx_t        in_b_y,
  input  fx_t        in_b_z,
  input  fx_t        in_scale,
  output logic       out_valid,
  output fx_t        out_res_x,
  output fx_t        out_res_y,
  output fx_t        out_res_z,
  output fx_t        out_scalar_out,
  output logic       out_overflow,
  output logic       out_div_by_zero
);

  logic            push, q_full, q_empty, pop;
  qent_t           push_ent, head;
  logic            ex_v;
  logic [SQ_W-1:0] ex_sq;
  pay_t            ex_pay;

  // front end: accept and classify
  vmu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_func  (in_func),
    .in_a_x   (in_a_x),
    .in_a_y   (in_a_y),
    .in_a_z   (in_a_z),
    .in_b_x   (in_b_x),
    .in_b_y   (in_b_y),
    .in_b_z   (in_b_z),
    .in_scale (in_scale),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  // decoupling queue; the back end never stalls, so it drains every cycle
  assign pop = !q_empty;

  vmu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  // products, sums, rounding
  vmu_exec #(.FRAC_BITS(FRAC_BITS)) u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (pop),
    .in_ent  (head),
    .out_v   (ex_v),
    .out_sq  (ex_sq),
    .out_pay (ex_pay)
  );

  // square root, divide, output register
  vmu_root #(.FRAC_BITS(FRAC_BITS)) u_root (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_v            (ex_v),
    .in_sq           (ex_sq),
    .in_pay          (ex_pay),
    .out_valid       (out_valid),
    .out_res_x       (out_res_x),
    .out_res_y       (out_res_y),
    .out_res_z       (out_res_z),
    .out_scalar_out  (out_scalar_out),
    .out_overflow    (out_overflow),
    .out_div_by_zero (out_div_by_zero)
  );

endmodule

### src/vmu_front.sv
module vmu_front import vmu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_func,
  input  fx_t        in_a_x,
  input  fx_t        in_a_y,
  input  fx_t        in_a_z,
  input  fx_t        in_b_x,
  input  fx_t        in_b_y,
  input  fx_t        in_b_z,
  input  fx_t        in_scale,
  input  logic       q_full,
  output logic       push,
  output qent_t      push_ent
);

  logic  front_v_r, front_v_nxt;
  logic  accept;
  qent_t ent_r, ent_nxt;
  fx_t   a [NLANE];
  fx_t   b [NLANE];

  assign a[0] = in_a_x;
  assign a[1] = in_a_y;
  assign a[2] = in_a_z;
  assign b[0] = in_b_x;
  assign b[1] = in_b_y;
  assign b[2] = in_b_z;

  assign busy     = front_v_r && q_full;
  assign accept   = start && !busy;
  assign push     = front_v_r && !q_full;
  assign push_ent = ent_r;

  // pick multiplier operands per operation
  always_comb begin
    ent_nxt      = '{default: '0};
    ent_nxt.func = in_func;
    for (int i = 0; i < NLANE; i++) begin
      ent_nxt.a[i] = a[i];
      ent_nxt.b[i] = b[i];
    end
    case (in_func)
      FN_SCALE: begin
        for (int i = 0; i < NLANE; i++) begin
          ent_nxt.ma[i] = in_scale;
          ent_nxt.mb[i] = b[i];
        end
      end
      FN_DOT: begin
        for (int i = 0; i < NLANE; i++) begin
          ent_nxt.ma[i] = a[i];
          ent_nxt.mb[i] = b[i];
        end
      end
      FN_LEN, FN_NORM: begin
        for (int i = 0; i < NLANE; i++) begin
          ent_nxt.ma[i] = a[i];
          ent_nxt.mb[i] = a[i];
        end
      end
      FN_CROSS: begin
        ent_nxt.ma[0] = a[1]; ent_nxt.mb[0] = b[2];
        ent_nxt.na[0] = b[1]; ent_nxt.nb[0] = a[2];
        ent_nxt.ma[1] = a[2]; ent_nxt.mb[1] = b[0];
        ent_nxt.na[1] = b[2]; ent_nxt.nb[1] = a[0];
        ent_nxt.ma[2] = a[0]; ent_nxt.mb[2] = b[1];
        ent_nxt.na[2] = a[1]; ent_nxt.nb[2] = b[0];
      end
      default: ;
    endcase
  end

  always_comb begin
    front_v_nxt = front_v_r;
    if (accept) begin
      front_v_nxt = 1'b1;
    end else if (push) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

### src/vmu_queue.sv
module vmu_queue import vmu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t head
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

### src/vmu_exec.sv
module vmu_exec import vmu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  qent_t           in_ent,
  output logic            out_v,
  output logic [SQ_W-1:0] out_sq,
  output pay_t            out_pay
);

  localparam wide_t RND_HALF = 65'sd1 <<< (FRAC_BITS - 1);

  // stage 1: products, component sums or differences, and magnitudes
  logic        s1_v_r;
  logic [2:0]  s1_func_r;
  prod_t       s1_p_r   [NLANE];
  prod_t       s1_n_r   [NLANE];
  sum33_t      s1_as_r  [NLANE];
  logic [31:0] s1_mag_r [NLANE];
  logic        s1_neg_r [NLANE];

  always_ff @(posedge clk) begin
    s1_func_r <= in_ent.func;
    for (int i = 0; i < NLANE; i++) begin
      s1_p_r[i]   <= 64'(in_ent.ma[i]) * 64'(in_ent.mb[i]);
      s1_n_r[i]   <= 64'(in_ent.na[i]) * 64'(in_ent.nb[i]);
      s1_as_r[i]  <= (in_ent.func == FN_SUB) ? (33'(in_ent.a[i]) - 33'(in_ent.b[i]))
                                             : (33'(in_ent.a[i]) + 33'(in_ent.b[i]));
      s1_mag_r[i] <= in_ent.a[i][31] ? 32'(-in_ent.a[i]) : 32'(in_ent.a[i]);
      s1_neg_r[i] <= in_ent.a[i][31];
    end
  end

  // stage 2: full-width differences and the three-term sum
  logic        s2_v_r;
  logic [2:0]  s2_func_r;
  wide_t       s2_t_r   [NLANE];
  wide_t       s2_sum_r;
  sum33_t      s2_as_r  [NLANE];
  logic [31:0] s2_mag_r [NLANE];
  logic        s2_neg_r [NLANE];

  always_ff @(posedge clk) begin
    s2_func_r <= s1_func_r;
    s2_sum_r  <= 65'(s1_p_r[0]) + 65'(s1_p_r[1]) + 65'(s1_p_r[2]);
    for (int i = 0; i < NLANE; i++) begin
      s2_t_r[i]   <= 65'(s1_p_r[i]) - 65'(s1_n_r[i]);
      s2_as_r[i]  <= s1_as_r[i];
      s2_mag_r[i] <= s1_mag_r[i];
      s2_neg_r[i] <= s1_neg_r[i];
    end
  end

  // stage 3: round, saturate and settle the non-root results
  logic            o_v_r;
  logic [SQ_W-1:0] o_sq_r;
  pay_t            o_pay_r, pay_nxt;

  always_comb begin
    sat_t st;
    st           = '{default: '0};
    pay_nxt      = '{default: '0};
    pay_nxt.func = s2_func_r;
    for (int i = 0; i < NLANE; i++) begin
      pay_nxt.mag[i] = s2_mag_r[i];
      pay_nxt.neg[i] = s2_neg_r[i];
    end
    case (s2_func_r)
      FN_ADD, FN_SUB: begin
        for (int i = 0; i < NLANE; i++) begin
          st             = sat32(65'(s2_as_r[i]));
          pay_nxt.r[i]   = st.val;
          pay_nxt.ovf    = pay_nxt.ovf | st.hit;
        end
      end
      FN_SCALE, FN_CROSS: begin
        for (int i = 0; i < NLANE; i++) begin
          st             = sat32((s2_t_r[i] + RND_HALF) >>> FRAC_BITS);
          pay_nxt.r[i]   = st.val;
          pay_nxt.ovf    = pay_nxt.ovf | st.hit;
        end
      end
      FN_DOT: begin
        st          = sat32((s2_sum_r + RND_HALF) >>> FRAC_BITS);
        pay_nxt.sc  = st.val;
        pay_nxt.ovf = st.hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    o_sq_r  <= s2_sum_r[SQ_W-1:0];
    o_pay_r <= pay_nxt;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      o_v_r  <= s2_v_r;
    end
  end

  assign out_v   = o_v_r;
  assign out_sq  = o_sq_r;
  assign out_pay = o_pay_r;

endmodule

### src/vmu_root.sv
module vmu_root import vmu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  logic [SQ_W-1:0] in_sq,
  input  pay_t            in_pay,
  output logic            out_valid,
  output fx_t             out_res_x,
  output fx_t             out_res_y,
  output fx_t             out_res_z,
  output fx_t             out_scalar_out,
  output logic            out_overflow,
  output logic            out_div_by_zero
);

  localparam int DIV_ST = FRAC_BITS + 1;

  // square root: one result bit per stage
  logic            sv_r    [ROOT_STAGES];
  logic [33:0]     srem_r  [ROOT_STAGES];
  logic [31:0]     sroot_r [ROOT_STAGES];
  logic [SQ_W-1:0] sx_r    [ROOT_STAGES];
  pay_t            sp_r    [ROOT_STAGES];

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_sqrt
    logic            v_in;
    logic [33:0]     rem_in, rem_nxt;
    logic [31:0]     root_in, root_nxt;
    logic [SQ_W-1:0] x_in;
    pay_t            pay_in;
    logic [35:0]     cur, trial;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = in_sq;
      assign pay_in  = in_pay;
    end else begin : g_next
      assign v_in    = sv_r[k-1];
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
      assign x_in    = sx_r[k-1];
      assign pay_in  = sp_r[k-1];
    end

    always_comb begin
      cur   = {rem_in, x_in[SQ_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      if (cur >= trial) begin
        rem_nxt  = 34'(cur - trial);
        root_nxt = {root_in[30:0], 1'b1};
      end else begin
        rem_nxt  = cur[33:0];
        root_nxt = {root_in[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else begin
        sv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      srem_r[k]  <= rem_nxt;
      sroot_r[k] <= root_nxt;
      sx_r[k]    <= {x_in[SQ_W-3:0], 2'b00};
      sp_r[k]    <= pay_in;
    end
  end

  // normalize: restoring divide of |a| * 2^FRAC_BITS by the length
  logic             dv_r   [DIV_ST];
  logic [31:0]      dlen_r [DIV_ST];
  logic [31:0]      dr_r   [DIV_ST][NLANE];
  logic [FRAC_BITS:0] dq_r [DIV_ST][NLANE];
  pay_t             dp_r   [DIV_ST];

  for (genvar s = 0; s < DIV_ST; s++) begin : g_div
    logic               v_in;
    logic [31:0]        len_in;
    pay_t               pay_in;
    logic [31:0]        r_in  [NLANE];
    logic [FRAC_BITS:0] q_in  [NLANE];
    logic               nb    [NLANE];
    logic [32:0]        cur   [NLANE];
    logic [31:0]        r_nxt [NLANE];
    logic [FRAC_BITS:0] q_nxt [NLANE];

    if (s == 0) begin : g_first
      assign v_in   = sv_r[ROOT_STAGES-1];
      assign len_in = sroot_r[ROOT_STAGES-1];
      assign pay_in = sp_r[ROOT_STAGES-1];
      for (genvar i = 0; i < NLANE; i++) begin : g_ln
        assign r_in[i] = sp_r[ROOT_STAGES-1].mag[i] >> 1;
        assign q_in[i] = '0;
        assign nb[i]   = sp_r[ROOT_STAGES-1].mag[i][0];
      end
    end else begin : g_next
      assign v_in   = dv_r[s-1];
      assign len_in = dlen_r[s-1];
      assign pay_in = dp_r[s-1];
      for (genvar i = 0; i < NLANE; i++) begin : g_ln
        assign r_in[i] = dr_r[s-1][i];
        assign q_in[i] = dq_r[s-1][i];
        assign nb[i]   = 1'b0;
      end
    end

    always_comb begin
      for (int i = 0; i < NLANE; i++) begin
        cur[i] = {r_in[i], nb[i]};
        if (cur[i] >= {1'b0, len_in}) begin
          r_nxt[i] = 32'(cur[i] - {1'b0, len_in});
          q_nxt[i] = {q_in[i][FRAC_BITS-1:0], 1'b1};
        end else begin
          r_nxt[i] = cur[i][31:0];
          q_nxt[i] = {q_in[i][FRAC_BITS-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s] <= 1'b0;
      end else begin
        dv_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dlen_r[s] <= len_in;
      dp_r[s]   <= pay_in;
      for (int i = 0; i < NLANE; i++) begin
        dr_r[s][i] <= r_nxt[i];
        dq_r[s][i] <= q_nxt[i];
      end
    end
  end

  // output select and register
  pay_t        fp;
  logic [31:0] flen;
  fx_t         res_nxt [NLANE];
  fx_t         sc_nxt;
  logic        ovf_nxt, dz_nxt;
  logic        ov_r, ovf_r, dz_r;
  fx_t         res_r [NLANE];
  fx_t         sc_r;

  assign fp   = dp_r[DIV_ST-1];
  assign flen = dlen_r[DIV_ST-1];

  always_comb begin
    logic [31:0] qv;
    for (int i = 0; i < NLANE; i++) begin
      res_nxt[i] = fp.r[i];
    end
    sc_nxt  = fp.sc;
    ovf_nxt = fp.ovf;
    dz_nxt  = 1'b0;
    qv      = '0;
    case (fp.func)
      FN_LEN: begin
        if (flen[31]) begin
          sc_nxt  = FX_MAX;
          ovf_nxt = 1'b1;
        end else begin
          sc_nxt = flen;
        end
      end
      FN_NORM: begin
        if (flen == '0) begin
          dz_nxt = 1'b1;
        end else begin
          for (int i = 0; i < NLANE; i++) begin
            qv         = 32'(dq_r[DIV_ST-1][i]);
            res_nxt[i] = fp.neg[i] ? -qv : qv;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_r[DIV_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      res_r[i] <= res_nxt[i];
    end
    sc_r  <= sc_nxt;
    ovf_r <= ovf_nxt;
    dz_r  <= dz_nxt;
  end

  assign out_valid       = ov_r;
  assign out_res_x       = res_r[0];
  assign out_res_y       = res_r[1];
  assign out_res_z       = res_r[2];
  assign out_scalar_out  = sc_r;
  assign out_overflow    = ovf_r;
  assign out_div_by_zero = dz_r;

  // a zero vector normalizes to all zeros without saturation
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |->
      out_res_x == '0 && out_res_y == '0 && out_res_z == '0 && out_scalar_out == '0)
    else $error("div_by_zero word carries nonzero result");

  a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> !out_overflow)
    else $error("div_by_zero and overflow together");

  // each normalized component is at most one in magnitude
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DIV_ST-1] && fp.func == FN_NORM && flen != '0 |->
      (!dq_r[DIV_ST-1][0][FRAC_BITS] || dq_r[DIV_ST-1][0][FRAC_BITS-1:0] == '0) &&
      (!dq_r[DIV_ST-1][1][FRAC_BITS] || dq_r[DIV_ST-1][1][FRAC_BITS-1:0] == '0) &&
      (!dq_r[DIV_ST-1][2][FRAC_BITS] || dq_r[DIV_ST-1][2][FRAC_BITS-1:0] == '0))
    else $error("normalize quotient above one");

endmodule

### verif/vector3_math_unit_tb.sv
`timescale 1ns / 1ps

module vector3_math_unit_tb;
  import vmu_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 39;
  localparam int N_RANDOM = 530;
  localparam longint CYCLE_LIMIT = 400000;

  // one input word as the block sees it
  typedef struct {
    logic [2:0] func;
    fx_t ax, ay, az, bx, by, bz, s;
  } vec_op_t;

  // one result word
  typedef struct {
    fx_t rx, ry, rz, sc;
    logic ovf, dz;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_func = FN_ADD;
  fx_t in_a_x = '0, in_a_y = '0, in_a_z = '0;
  fx_t in_b_x = '0, in_b_y = '0, in_b_z = '0;
  fx_t in_scale = '0;
  logic out_valid;
  fx_t out_res_x, out_res_y, out_res_z, out_scalar_out;
  logic out_overflow, out_div_by_zero;

  int n_errors = 0;
  longint n_cycles = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  vector3_math_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_scale(in_scale),
    .out_valid(out_valid), .out_res_x(out_res_x), .out_res_y(out_res_y),
    .out_res_z(out_res_z), .out_scalar_out(out_scalar_out),
    .out_overflow(out_overflow), .out_div_by_zero(out_div_by_zero)
  );

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // predicts vector ALU results and keeps them in order
  class vec_alu_scoreboard;
    vec_res_t pending[$];

    // clamp to 32-bit signed, noting saturation
    static function fx_t clamp(input logic signed [127:0] v, inout logic hit);
      if (v > 128'sd2147483647) begin
        hit = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      if (v < -128'sd2147483648) begin
        hit = 1'b1;
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    // round to nearest, ties up, then clamp
    static function fx_t round_prod(input logic signed [127:0] v, inout logic hit);
      logic signed [127:0] r;
      r = (v + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
      return clamp(r, hit);
    endfunction

    static function logic [63:0] int_sqrt(input logic [127:0] x);
      logic [127:0] r, b;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        b = r | (128'd1 << i);
        if (b * b <= x) r = b;
      end
      return r[63:0];
    endfunction

    function automatic vec_res_t compute(input vec_op_t op);
      vec_res_t o;
      logic signed [127:0] ax, ay, az, bx, by, bz, s, len;
      logic [127:0] sq;
      logic hit;
      o = '{default: '0};
      hit = 1'b0;
      ax = op.ax; ay = op.ay; az = op.az;
      bx = op.bx; by = op.by; bz = op.bz; s = op.s;
      case (op.func)
        FN_ADD: begin
          o.rx = clamp(ax + bx, hit); o.ry = clamp(ay + by, hit); o.rz = clamp(az + bz, hit);
        end
        FN_SUB: begin
          o.rx = clamp(ax - bx, hit); o.ry = clamp(ay - by, hit); o.rz = clamp(az - bz, hit);
        end
        FN_SCALE: begin
          o.rx = round_prod(s * bx, hit);
          o.ry = round_prod(s * by, hit);
          o.rz = round_prod(s * bz, hit);
        end
        FN_DOT: o.sc = round_prod(ax * bx + ay * by + az * bz, hit);
        FN_LEN, FN_NORM: begin
          sq = ax * ax + ay * ay + az * az;
          len = $signed({64'd0, int_sqrt(sq)});
          if (op.func == FN_LEN) o.sc = clamp(len, hit);
          else if (len == 0) o.dz = 1'b1;
          else begin
            // SV division truncates toward zero
            o.rx = clamp((ax <<< FRAC) / len, hit);
            o.ry = clamp((ay <<< FRAC) / len, hit);
            o.rz = clamp((az <<< FRAC) / len, hit);
          end
        end
        FN_CROSS: begin
          o.rx = round_prod(ay * bz - by * az, hit);
          o.ry = round_prod(az * bx - bz * ax, hit);
          o.rz = round_prod(ax * by - ay * bx, hit);
        end
        default: ;
      endcase
      o.ovf = hit;
      return o;
    endfunction

    function void note_input(input vec_op_t op);
      pending.push_back(compute(op));
    endfunction

    task check_result(input vec_res_t got);
      vec_res_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      exp_r = pending.pop_front();
      if (got.rx !== exp_r.rx)
        report_mismatch($sformatf("res_x %h exp %h", got.rx, exp_r.rx));
      if (got.ry !== exp_r.ry)
        report_mismatch($sformatf("res_y %h exp %h", got.ry, exp_r.ry));
      if (got.rz !== exp_r.rz)
        report_mismatch($sformatf("res_z %h exp %h", got.rz, exp_r.rz));
      if (got.sc !== exp_r.sc)
        report_mismatch($sformatf("scalar %h exp %h", got.sc, exp_r.sc));
      if (got.ovf !== exp_r.ovf)
        report_mismatch($sformatf("overflow %b exp %b", got.ovf, exp_r.ovf));
      if (got.dz !== exp_r.dz)
        report_mismatch($sformatf("div_by_zero %b exp %b", got.dz, exp_r.dz));
    endtask
  endclass

  vec_alu_scoreboard sb = new();

  // output monitor and cycle limit
  always @(posedge clk) begin
    n_cycles++;
    if (rst_n && out_valid)
      sb.check_result('{out_res_x, out_res_y, out_res_z, out_scalar_out,
                        out_overflow, out_div_by_zero});
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // drive one word; hold start until accepted, start drops only while idling
  task automatic send_word(input vec_op_t op);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_func <= op.func;
    in_a_x <= op.ax; in_a_y <= op.ay; in_a_z <= op.az;
    in_b_x <= op.bx; in_b_y <= op.by; in_b_z <= op.bz;
    in_scale <= op.s;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(op);
    @(negedge clk);
  endtask

  // random component: mostly small magnitudes, sometimes full range or extremes
  function automatic fx_t rand_fx();
    case ($urandom_range(5, 0))
      0: return $urandom();
      1: return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return 32'(signed'($urandom_range(2000, 0)) - 1000);
      default: return $signed($urandom()) >>> $urandom_range(20, 4);
    endcase
  endfunction

  function automatic vec_op_t rand_word();
    vec_op_t op;
    op.func = $urandom_range(7, 0) == 7 ? FN_RSVD : 3'($urandom_range(6, 0));
    op.ax = rand_fx(); op.ay = rand_fx(); op.az = rand_fx();
    op.bx = rand_fx(); op.by = rand_fx(); op.bz = rand_fx();
    op.s = rand_fx();
    if (op.func == FN_NORM && $urandom_range(9, 0) == 0) begin
      op.ax = 0; op.ay = 0; op.az = 0;
    end
    return op;
  endfunction

  initial begin
    fx_t mx, mn;
    int k;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every operation, zero normalize, unused code
    send_word('{FN_ADD, mx, mx, mn, mx, 1, mn, 0});
    send_word('{FN_ADD, mx, mn, -1, 1, -1, mx, 0});
    send_word('{FN_SUB, mn, mx, 0, 1, -1, mn, 0});
    send_word('{FN_SUB, -1, -1, -1, mx, mn, 0, 0});
    send_word('{FN_SCALE, 0, 0, 0, mx, mn, 32'sh0001_8000, mn});
    send_word('{FN_SCALE, 0, 0, 0, 32'sh0000_8000, -32'sh0000_8000, 1, 32'sh0000_0001});
    send_word('{FN_SCALE, 0, 0, 0, 3, -3, 32'sh0001_0000, 32'sh0000_8000});
    send_word('{FN_DOT, mx, mx, mx, mx, mx, mx, 0});
    send_word('{FN_DOT, mn, mn, mn, mx, mx, mx, 0});
    send_word('{FN_DOT, 32'sh0001_0000, 2, 0, 32'sh0002_0000, 32'sh0000_8000, 0, 0});
    send_word('{FN_LEN, mn, mn, mn, 0, 0, 0, 0});
    send_word('{FN_LEN, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0});
    send_word('{FN_LEN, 0, 0, 0, 0, 0, 0, 0});
    send_word('{FN_NORM, 0, 0, 0, mx, mx, mx, mx});
    send_word('{FN_NORM, 1, 0, 0, 0, 0, 0, 0});
    send_word('{FN_NORM, mn, mx, 7, 0, 0, 0, 0});
    send_word('{FN_NORM, -32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0});
    send_word('{FN_CROSS, mx, mn, mx, mn, mx, mn, 0});
    send_word('{FN_CROSS, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0, 0});
    send_word('{FN_CROSS, mn, mn, mn, mx, 1, -1, 0});
    send_word('{FN_RSVD, mx, mn, -1, mx, mn, -1, mx});

    // random phases with different sender idling
    for (k = 0; k < N_RANDOM; k++) begin
      case (k / (N_RANDOM / 4))
        0: idle_pct = 0;
        1: idle_pct = 67;
        2: idle_pct = 0;
        default: idle_pct = 7;
      endcase
      send_word(rand_word());
    end
    start <= 1'b0;

    // drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && sb.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
